// ----- sv/tetl_pkg.sv -----
// Shared types and constants for the tab expander with line trimming.
`timescale 1ns / 1ps

package tetl_pkg;

    // Byte codes
    localparam logic [7:0] TERM_CODE    = 8'h00;
    localparam logic [7:0] TAB_CODE     = 8'h09;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    // Tab stops every eight columns
    localparam logic [2:0] TAB_MASK = 3'd7;

    // Line store bound and the cap it places on the buffer size
    localparam int LINE_MAX  = 256;
    localparam int LIMIT_CAP = (LINE_MAX < 256) ? LINE_MAX : 256;

    // Positions kept back from the buffer size
    localparam int RESERVED_POS = 2;

    // Configuration port
    localparam int          APB_ADDR_W      = 3;
    localparam int          APB_DATA_W      = 32;
    localparam int          BUF_SIZE_W      = 9;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 9'd256;
    localparam logic        REG_BUFFER_SIZE = 1'b0;

    // One result beat
    typedef struct packed {
        logic [7:0] position;
        logic [7:0] out_char;
        logic       is_length;
        logic [7:0] line_length;
        logic       last;
    } result_t;

    // Core to result register
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_beat_t;

endpackage

// ----- sv/tetl_cfg_regs.sv -----
// Configuration register file and usable column limit.
`timescale 1ns / 1ps

module tetl_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tetl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tetl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tetl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [7:0]                          limit
);

    logic [tetl_pkg::BUF_SIZE_W-1:0] buffer_size_reg;
    logic [tetl_pkg::BUF_SIZE_W-1:0] size_capped;
    logic                            sel_size;

    assign sel_size = (paddr[2] == tetl_pkg::REG_BUFFER_SIZE);
    assign pready   = 1'b1;

    // Write the buffer size on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= tetl_pkg::BUF_SIZE_RESET;
        end else if (psel && penable && pwrite && sel_size) begin
            buffer_size_reg <= pwdata[tetl_pkg::BUF_SIZE_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (sel_size) begin
            prdata = {{(tetl_pkg::APB_DATA_W-tetl_pkg::BUF_SIZE_W){1'b0}}, buffer_size_reg};
        end
    end

    // Clamp to the line store, then keep two positions back
    always_comb begin
        if (buffer_size_reg > tetl_pkg::BUF_SIZE_W'(tetl_pkg::LIMIT_CAP)) begin
            size_capped = tetl_pkg::BUF_SIZE_W'(tetl_pkg::LIMIT_CAP);
        end else begin
            size_capped = buffer_size_reg;
        end
        if (size_capped < tetl_pkg::BUF_SIZE_W'(tetl_pkg::RESERVED_POS)) begin
            limit = '0;
        end else begin
            limit = 8'(size_capped - tetl_pkg::BUF_SIZE_W'(tetl_pkg::RESERVED_POS));
        end
    end

endmodule

// ----- sv/tetl_core.sv -----
// Input register, line state and the step logic, one result per cycle while the result register is free.
`timescale 1ns / 1ps

module tetl_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_character,
    input  logic [7:0]             limit,
    input  logic                   out_free,
    output tetl_pkg::result_beat_t res
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic [7:0] column_reg;
    logic [7:0] nonspace_end_reg;
    logic [7:0] nonspace_end_before_last_reg;
    logic       last_was_newline_reg;

    logic       step;
    logic       is_term;
    logic       is_tab;
    logic       line_full;
    logic       done;
    logic [7:0] wr_char;
    logic [7:0] col_inc;

    // Decode the held byte
    assign step      = in_valid_reg && out_free;
    assign is_term   = (in_char_reg == tetl_pkg::TERM_CODE);
    assign is_tab    = (in_char_reg == tetl_pkg::TAB_CODE);
    assign line_full = (column_reg >= limit);
    assign wr_char   = is_tab ? tetl_pkg::SPACE_CODE : in_char_reg;
    assign col_inc   = column_reg + 8'd1;

    // A tab stays held until the next stop or the limit
    always_comb begin
        done = 1'b1;
        if (!is_term && !line_full && is_tab) begin
            done = ((col_inc[2:0] & tetl_pkg::TAB_MASK) == 3'd0) || (col_inc >= limit);
        end
    end

    assign s_ready = !in_valid_reg || (step && done);

    // Build the result beat
    always_comb begin
        res.valid = step && (is_term || !line_full);
        if (is_term) begin
            res.data.position    = '0;
            res.data.out_char    = '0;
            res.data.is_length   = 1'b1;
            res.data.line_length = last_was_newline_reg ? nonspace_end_before_last_reg
                                                        : nonspace_end_reg;
            res.data.last        = 1'b1;
        end else begin
            res.data.position    = column_reg;
            res.data.out_char    = wr_char;
            res.data.is_length   = 1'b0;
            res.data.line_length = '0;
            res.data.last        = done;
        end
    end

    // Hold the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step && done) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
        end
    end

    // Advance the line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg                   <= '0;
            nonspace_end_reg             <= '0;
            nonspace_end_before_last_reg <= '0;
            last_was_newline_reg         <= 1'b0;
        end else if (step) begin
            if (is_term) begin
                column_reg                   <= '0;
                nonspace_end_reg             <= '0;
                nonspace_end_before_last_reg <= '0;
                last_was_newline_reg         <= 1'b0;
            end else if (!line_full) begin
                nonspace_end_before_last_reg <= nonspace_end_reg;
                if (wr_char != tetl_pkg::SPACE_CODE) begin
                    nonspace_end_reg <= col_inc;
                end
                last_was_newline_reg <= (wr_char == tetl_pkg::NEWLINE_CODE);
                column_reg           <= col_inc;
            end
        end
    end

endmodule

// ----- sv/tetl_out_reg.sv -----
// Result register between the step logic and the result channel.
`timescale 1ns / 1ps

module tetl_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tetl_pkg::result_beat_t res,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tetl_pkg::result_t      m_data
);

    logic              m_valid_reg;
    tetl_pkg::result_t data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = data_reg;

    // Load a new beat whenever the register drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            data_reg <= res.data;
        end
    end

endmodule

// ----- sv/tab_expand_trim_line.sv -----
// Top level: tab expander with trailing newline and space trimming.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_character
//   m_       out        m_valid / m_ready   m_position, m_out_char, m_is_length,
//                                           m_line_length, m_last
//   APB      in         psel / penable      paddr, pwdata, prdata (buffer_size at 0x0)
//
// An ordinary byte or a terminator gives one beat; a tab gives one space beat
// per column up to the next tab stop, up to eight, while the input holds.
// A byte other than a terminator that lands on a full line is dropped with no beat.
// A byte passes through the input register and then the result register.
// Synchronous active-low reset clears the line state and sets buffer_size to 256.
// A stalled m_ready holds the result register and, through it, the input.
`timescale 1ns / 1ps

module tab_expand_trim_line (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_character,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_position,
    output logic [7:0]                      m_out_char,
    output logic                            m_is_length,
    output logic [7:0]                      m_line_length,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tetl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tetl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tetl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                   out_free;
    logic [7:0]             limit;
    tetl_pkg::result_beat_t res;
    tetl_pkg::result_t      m_data;

    tetl_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    tetl_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .limit       (limit),
        .out_free    (out_free),
        .res         (res)
    );

    tetl_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign m_position    = m_data.position;
    assign m_out_char    = m_data.out_char;
    assign m_is_length   = m_data.is_length;
    assign m_line_length = m_data.line_length;
    assign m_last        = m_data.last;

    // A length beat closes its input and carries no character
    a_length_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_length |-> m_last && m_position == 8'd0 && m_out_char == 8'd0)
        else $error("length beat malformed");

    // Only a tab gives more than one beat, and never across a tab stop
    a_tab_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !m_is_length && m_out_char == tetl_pkg::SPACE_CODE
                               && (m_position[2:0] != tetl_pkg::TAB_MASK))
        else $error("non-last beat outside a tab run");

    // Character beats stay inside the usable columns
    a_position_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_length |-> m_position <= 8'd253 && m_line_length == 8'd0)
        else $error("character beat out of range");

    // Input is held while a tab run is still being written
    a_hold_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && out_free && !res.data.last |-> !s_ready)
        else $error("input taken during a tab run");

endmodule
